### rtl/pdds_pkg.sv
`timescale 1ns / 1ps

package pdds_pkg;

	// default fraction bits of error, integral, turn rate and base rate
	localparam int FRAC_BITS_DEF = 24;

	localparam int GAIN_W    = 24;             // unsigned Q8.16 gains
	localparam int GAIN_FRAC = 16;
	localparam int LIM_W     = 31;             // limits and base rate
	localparam int SENS_W    = 8;
	localparam int SPD_W     = 8;
	localparam int CFG_IDX_W = 3;

	localparam int SUM_W  = 32;                // clamped integral
	localparam int PID_W  = 42;                // |pid| < 2^40
	localparam int MA_W   = 31;                // multiplier operand a
	localparam int PROD_W = MA_W + GAIN_W;
	localparam int GLO_W  = 24;                // low slice of |pid| for the overall gain
	localparam int G_W    = 50;                // |pid * kg| < 2^49
	localparam int RATE_W = 34;                // base -/+ turn, signed

	localparam int ERR_DIV   = 6375;
	localparam int SPEED_NUM = 9549296;
	localparam int SPEED_DEN = 1000000;

	localparam logic [GAIN_W-1:0] KP_RST   = 24'd1966080;
	localparam logic [GAIN_W-1:0] KI_RST   = 24'd0;
	localparam logic [GAIN_W-1:0] KD_RST   = 24'd0;
	localparam logic [GAIN_W-1:0] KG_RST   = 24'd65536;
	localparam logic [LIM_W-1:0]  ILIM_RST = 31'd6039798;
	localparam logic [LIM_W-1:0]  TLIM_RST = 31'd167772160;
	localparam logic [LIM_W-1:0]  BASE_RST = 31'd315806419;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP,
		REG_KI,
		REG_KD,
		REG_KG,
		REG_ILIM,
		REG_TLIM,
		REG_BASE
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [GAIN_W-1:0] kg;
		logic [LIM_W-1:0]  ilim;
		logic [LIM_W-1:0]  tlim;
		logic [LIM_W-1:0]  base;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_PID_SUM,
		ST_MUL_GLO,
		ST_MUL_GHI,
		ST_G_SUM,
		ST_TURN,
		ST_SEARCH,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		MS_NONE,
		MS_P,
		MS_I,
		MS_D,
		MS_GLO,
		MS_GHI
	} mul_sel_t;

	typedef enum logic [2:0] {
		AC_NONE,
		AC_PID_FIRST,
		AC_PID_ADD,
		AC_G_LO,
		AC_G_HI
	} acc_op_t;

	typedef struct packed {
		logic       load_in;
		logic       upd_err;
		mul_sel_t   mul_sel;
		acc_op_t    acc_op;
		logic       turn;
		logic       search;
		logic [2:0] bit_idx;
		logic       load_out;
	} dp_cmd_t;

	// error magnitude for |2c-255| = 2k+1, rounded half up
	function automatic logic [63:0] err_mag(int frac, int k);
		logic [63:0] num;
		num = (64'(2 * k + 1) << frac) + 64'(ERR_DIV / 2);
		return num / 64'(ERR_DIV);
	endfunction

	// smallest rate whose scaled speed reaches k
	function automatic logic [63:0] speed_thr(int frac, int k);
		logic [63:0] num;
		num = (64'(k) * 64'(SPEED_DEN)) << frac;
		return (num + 64'(SPEED_NUM - 1)) / 64'(SPEED_NUM);
	endfunction

endpackage

### rtl/pid_differential_drive_speed.sv
`timescale 1ns / 1ps

// Line-following speed controller. Each item is one sensor byte; it is turned
// into a signed line error (Q.FRAC_BITS), added to an integral clamped to
// +/- integral_limit, and fed to a PID whose sum is scaled by overall_gain and
// clamped to +/- turn_limit. The result item carries the two wheel speeds,
// (base_rate -/+ turn) * 9.549296 truncated and clamped to 0..255, and a flag
// that the error is non-negative. The block works on one item at a time and
// takes no new item until the last result is loaded into the output register.
// One shared 31x24 multiplier forms the five partial products in turn, and
// both speeds come out of an 8-step search against a threshold table, one
// bit per cycle. The result sits in an output register, so the next item can
// be accepted while it waits. Configuration writes are always taken (cfg_ready
// high) and must only happen while idle.
module pid_differential_drive_speed #(
	parameter int FRAC_BITS = pdds_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input items
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pdds_pkg::SENS_W-1:0]        sensor_byte,
	// result items
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pdds_pkg::SPD_W-1:0]         left_speed,
	output logic [pdds_pkg::SPD_W-1:0]         right_speed,
	output logic                               error_non_negative,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pdds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdds_pkg::LIM_W-1:0]         cfg_data
);

	pdds_pkg::cfg_t    cfg;     // gains, limits, base rate
	pdds_pkg::dp_cmd_t cmd;     // per-cycle datapath command

	// register file, 24-bit gains take the low bits of cfg_data
	pdds_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: error, five multiplies, clamp, speed search, output load
	pdds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// error table, integral, shared multiplier, accumulators, output register
	pdds_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.cfg                (cfg),
		.sensor_byte        (sensor_byte),
		.left_speed         (left_speed),
		.right_speed        (right_speed),
		.error_non_negative (error_non_negative)
	);

endmodule

### rtl/pdds_cfg.sv
`timescale 1ns / 1ps

module pdds_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pdds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdds_pkg::LIM_W-1:0]         cfg_data,
	output pdds_pkg::cfg_t                     cfg
);

	pdds_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp   <= pdds_pkg::KP_RST;
			cfg_q.ki   <= pdds_pkg::KI_RST;
			cfg_q.kd   <= pdds_pkg::KD_RST;
			cfg_q.kg   <= pdds_pkg::KG_RST;
			cfg_q.ilim <= pdds_pkg::ILIM_RST;
			cfg_q.tlim <= pdds_pkg::TLIM_RST;
			cfg_q.base <= pdds_pkg::BASE_RST;
		end else if (cfg_valid) begin
			unique case (pdds_pkg::cfg_reg_t'(cfg_index))
				pdds_pkg::REG_KP:   cfg_q.kp   <= cfg_data[pdds_pkg::GAIN_W-1:0];
				pdds_pkg::REG_KI:   cfg_q.ki   <= cfg_data[pdds_pkg::GAIN_W-1:0];
				pdds_pkg::REG_KD:   cfg_q.kd   <= cfg_data[pdds_pkg::GAIN_W-1:0];
				pdds_pkg::REG_KG:   cfg_q.kg   <= cfg_data[pdds_pkg::GAIN_W-1:0];
				pdds_pkg::REG_ILIM: cfg_q.ilim <= cfg_data;
				pdds_pkg::REG_TLIM: cfg_q.tlim <= cfg_data;
				pdds_pkg::REG_BASE: cfg_q.base <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### rtl/pdds_ctrl.sv
`timescale 1ns / 1ps

module pdds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pdds_pkg::dp_cmd_t cmd
);

	pdds_pkg::state_t state_q, state_d;
	logic [2:0]       bit_q, bit_d;
	logic             out_valid_q, out_valid_d;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pdds_pkg::ST_IDLE;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			bit_q       <= bit_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		bit_d    = bit_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			pdds_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = pdds_pkg::ST_ERR;
				end
			end
			pdds_pkg::ST_ERR: begin
				cmd.upd_err = 1'b1;
				state_d     = pdds_pkg::ST_MUL_P;
			end
			pdds_pkg::ST_MUL_P: begin
				cmd.mul_sel = pdds_pkg::MS_P;
				state_d     = pdds_pkg::ST_MUL_I;
			end
			pdds_pkg::ST_MUL_I: begin
				cmd.mul_sel = pdds_pkg::MS_I;
				cmd.acc_op  = pdds_pkg::AC_PID_FIRST;
				state_d     = pdds_pkg::ST_MUL_D;
			end
			pdds_pkg::ST_MUL_D: begin
				cmd.mul_sel = pdds_pkg::MS_D;
				cmd.acc_op  = pdds_pkg::AC_PID_ADD;
				state_d     = pdds_pkg::ST_PID_SUM;
			end
			pdds_pkg::ST_PID_SUM: begin
				cmd.acc_op = pdds_pkg::AC_PID_ADD;
				state_d    = pdds_pkg::ST_MUL_GLO;
			end
			pdds_pkg::ST_MUL_GLO: begin
				cmd.mul_sel = pdds_pkg::MS_GLO;
				state_d     = pdds_pkg::ST_MUL_GHI;
			end
			pdds_pkg::ST_MUL_GHI: begin
				cmd.mul_sel = pdds_pkg::MS_GHI;
				cmd.acc_op  = pdds_pkg::AC_G_LO;
				state_d     = pdds_pkg::ST_G_SUM;
			end
			pdds_pkg::ST_G_SUM: begin
				cmd.acc_op = pdds_pkg::AC_G_HI;
				state_d    = pdds_pkg::ST_TURN;
			end
			pdds_pkg::ST_TURN: begin
				cmd.turn = 1'b1;
				bit_d    = '1;
				state_d  = pdds_pkg::ST_SEARCH;
			end
			pdds_pkg::ST_SEARCH: begin
				cmd.search  = 1'b1;
				cmd.bit_idx = bit_q;
				if (bit_q == '0) begin
					state_d = pdds_pkg::ST_DONE;
				end else begin
					bit_d = bit_q - 3'd1;
				end
			end
			pdds_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = pdds_pkg::ST_IDLE;
				end
			end
			default: state_d = pdds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

endmodule

### rtl/pdds_dp.sv
`timescale 1ns / 1ps

module pdds_dp #(
	parameter int FRAC_BITS = pdds_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pdds_pkg::dp_cmd_t             cmd,
	input  pdds_pkg::cfg_t                cfg,
	input  logic [pdds_pkg::SENS_W-1:0]   sensor_byte,
	output logic [pdds_pkg::SPD_W-1:0]    left_speed,
	output logic [pdds_pkg::SPD_W-1:0]    right_speed,
	output logic                          error_non_negative
);

	localparam int MAG_W  = FRAC_BITS - 4;   // |error| < 2^-4
	localparam int EW     = MAG_W + 1;
	localparam int DW     = EW + 1;
	localparam int SUM_W  = pdds_pkg::SUM_W;
	localparam int PID_W  = pdds_pkg::PID_W;
	localparam int MA_W   = pdds_pkg::MA_W;
	localparam int GAIN_W = pdds_pkg::GAIN_W;
	localparam int PROD_W = pdds_pkg::PROD_W;
	localparam int GF     = pdds_pkg::GAIN_FRAC;
	localparam int GLO_W  = pdds_pkg::GLO_W;
	localparam int G_W    = pdds_pkg::G_W;
	localparam int LIM_W  = pdds_pkg::LIM_W;
	localparam int RATE_W = pdds_pkg::RATE_W;
	localparam int SPD_W  = pdds_pkg::SPD_W;
	localparam int SENS_W = pdds_pkg::SENS_W;

	// constant tables
	logic [MAG_W-1:0]         err_tab [2**(SENS_W-1)];
	logic signed [RATE_W-1:0] thr_tab [2**SPD_W];

	for (genvar k = 0; k < 2**(SENS_W-1); k++) begin : g_err
		assign err_tab[k] = MAG_W'(pdds_pkg::err_mag(FRAC_BITS, k));
	end

	for (genvar k = 0; k < 2**SPD_W; k++) begin : g_thr
		assign thr_tab[k] = RATE_W'(pdds_pkg::speed_thr(FRAC_BITS, k));
	end

	logic [SENS_W-1:0]        sens_q;
	logic signed [EW-1:0]     e_q;
	logic signed [EW-1:0]     last_q;
	logic signed [DW-1:0]     d_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     neg_q;
	logic signed [PID_W-1:0]  pid_q;
	logic [G_W-1:0]           g_q;
	logic signed [RATE_W-1:0] rate_l_q, rate_r_q;
	logic [SPD_W-1:0]         ql_q, qr_q;
	logic [SPD_W-1:0]         left_q, right_q;
	logic                     enn_q;

	// error lookup, symmetric about the center
	logic [SENS_W-2:0]        err_idx;
	logic signed [EW-1:0]     e_pos, e_new;
	logic signed [DW-1:0]     d_new;
	logic signed [SUM_W:0]    sum_wide, lim_pos, lim_neg;
	logic signed [SUM_W-1:0]  sum_new;

	assign err_idx  = sens_q[SENS_W-1] ? sens_q[SENS_W-2:0] : ~sens_q[SENS_W-2:0];
	assign e_pos    = signed'({1'b0, err_tab[err_idx]});
	assign e_new    = sens_q[SENS_W-1] ? e_pos : -e_pos;
	assign d_new    = DW'(e_new) - DW'(last_q);
	assign sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(e_new);
	assign lim_pos  = signed'((SUM_W+1)'(cfg.ilim));
	assign lim_neg  = -lim_pos;

	always_comb begin
		if (sum_wide > lim_pos) begin
			sum_new = SUM_W'(lim_pos);
		end else if (sum_wide < lim_neg) begin
			sum_new = SUM_W'(lim_neg);
		end else begin
			sum_new = SUM_W'(sum_wide);
		end
	end

	// multiplier operand select
	logic [EW-1:0]     e_abs;
	logic [DW-1:0]     d_abs;
	logic [SUM_W-1:0]  sum_abs;
	logic [PID_W-1:0]  pid_abs;
	logic [MA_W-1:0]   mul_a;
	logic [GAIN_W-1:0] mul_b;
	logic              mul_neg;

	assign e_abs   = e_q[EW-1] ? -e_q : e_q;
	assign d_abs   = d_q[DW-1] ? -d_q : d_q;
	assign sum_abs = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign pid_abs = pid_q[PID_W-1] ? -pid_q : pid_q;

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		case (cmd.mul_sel)
			pdds_pkg::MS_P: begin
				mul_a   = MA_W'(e_abs);
				mul_b   = cfg.kp;
				mul_neg = e_q[EW-1];
			end
			pdds_pkg::MS_I: begin
				mul_a   = sum_abs[MA_W-1:0];
				mul_b   = cfg.ki;
				mul_neg = sum_q[SUM_W-1];
			end
			pdds_pkg::MS_D: begin
				mul_a   = MA_W'(d_abs);
				mul_b   = cfg.kd;
				mul_neg = d_q[DW-1];
			end
			pdds_pkg::MS_GLO: begin
				mul_a = MA_W'(pid_abs[GLO_W-1:0]);
				mul_b = cfg.kg;
			end
			pdds_pkg::MS_GHI: begin
				mul_a = MA_W'(pid_abs[PID_W-2:GLO_W]);
				mul_b = cfg.kg;
			end
			default: ;
		endcase
	end

	// product scaled by the gain fraction, sign restored
	logic signed [PID_W-1:0] term_pos, term;

	assign term_pos = signed'(PID_W'(prod_q[PROD_W-1:GF]));
	assign term     = neg_q ? -term_pos : term_pos;

	// turn rate clamp and wheel rates
	logic [LIM_W-1:0]         turn_mag;
	logic signed [SUM_W-1:0]  turn_pos, turn;
	logic signed [RATE_W-1:0] base_ext;

	assign turn_mag = (g_q > G_W'(cfg.tlim)) ? cfg.tlim : g_q[LIM_W-1:0];
	assign turn_pos = signed'(SUM_W'(turn_mag));
	assign turn     = pid_q[PID_W-1] ? -turn_pos : turn_pos;
	assign base_ext = signed'(RATE_W'(cfg.base));

	// one bit of each speed per search step
	logic [SPD_W-1:0] cand_l, cand_r;

	assign cand_l = ql_q | (SPD_W'(1) << cmd.bit_idx);
	assign cand_r = qr_q | (SPD_W'(1) << cmd.bit_idx);

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			last_q <= '0;
		end else if (cmd.upd_err) begin
			sum_q  <= sum_new;
			last_q <= e_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sens_q <= sensor_byte;
		end
		if (cmd.upd_err) begin
			e_q <= e_new;
			d_q <= d_new;
		end
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		neg_q  <= mul_neg;
		case (cmd.acc_op)
			pdds_pkg::AC_PID_FIRST: pid_q <= term;
			pdds_pkg::AC_PID_ADD:   pid_q <= pid_q + term;
			pdds_pkg::AC_G_LO:      g_q   <= G_W'(prod_q[PROD_W-1:GF]);
			pdds_pkg::AC_G_HI:      g_q   <= g_q + (G_W'(prod_q) << (GLO_W - GF));
			default: ;
		endcase
		if (cmd.turn) begin
			rate_l_q <= base_ext - RATE_W'(turn);
			rate_r_q <= base_ext + RATE_W'(turn);
			ql_q     <= '0;
			qr_q     <= '0;
		end else if (cmd.search) begin
			if (rate_l_q >= thr_tab[cand_l]) begin
				ql_q <= cand_l;
			end
			if (rate_r_q >= thr_tab[cand_r]) begin
				qr_q <= cand_r;
			end
		end
		if (cmd.load_out) begin
			left_q  <= ql_q;
			right_q <= qr_q;
			enn_q   <= sens_q[SENS_W-1];
		end
	end

	assign left_speed         = left_q;
	assign right_speed        = right_q;
	assign error_non_negative = enn_q;

endmodule

### rtl/pdds_checker.sv
`timescale 1ns / 1ps

module pdds_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [pdds_pkg::SPD_W-1:0]  left_speed,
	input logic [pdds_pkg::SPD_W-1:0]  right_speed,
	input logic                        error_non_negative
);

	// items accepted but not yet delivered
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_speed)
			&& $stable(right_speed) && $stable(error_non_negative))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while another is in work");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without an accepted item");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items outstanding");

endmodule

bind pid_differential_drive_speed pdds_checker u_chk (.*);

### tb/sv/pid_differential_drive_speed_tb.sv
`timescale 1ns / 1ps

module pid_differential_drive_speed_tb;
	import pdds_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	// a register index past the last real register, writes to it are dropped
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 128;
	localparam int HOLD_CYCLES = 400;

	// one wheel command as the block reports it
	typedef struct packed {
		logic [SPD_W-1:0] l_speed;
		logic [SPD_W-1:0] r_speed;
		logic             non_neg;
	} wheel_cmd_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	// one row of the directed plan: a sensor item or a register write
	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [LIM_W-1:0]      data;
		bit                    typed;
		wheel_cmd_t            want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [SENS_W-1:0]     sensor_byte = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SPD_W-1:0]      left_speed;
	logic [SPD_W-1:0]      right_speed;
	logic                  error_non_negative;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [LIM_W-1:0]      cfg_data = '0;

	// driver asks the receiver for a long hold-off with this
	logic                  hold_kick = 1'b0;

	// controller state and registers as the testbench tracks them
	cfg_t                  model_cfg;
	longint                err_sum;
	longint                prev_err;

	wheel_cmd_t            pending_cmds[$];
	plan_row_t             plan[$];
	int                    errors = 0;

	pid_differential_drive_speed dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.sensor_byte        (sensor_byte),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.left_speed         (left_speed),
		.right_speed        (right_speed),
		.error_non_negative (error_non_negative),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// controller arithmetic
	// ---------------------------------------------------------------

	// sign(x) * floor(|x| * g / 2^16), wide enough that nothing is lost
	function automatic longint scaled_by_gain(longint x, logic [GAIN_W-1:0] g);
		logic [63:0] mag;
		logic [95:0] prod;
		longint      r;
		mag = (x < 0) ? 64'(-x) : 64'(x);
		prod = {32'b0, mag} * {72'b0, g};
		r = longint'(prod[79:16]);
		return (x < 0) ? -r : r;
	endfunction

	function automatic longint clamp_sym(longint v, logic [LIM_W-1:0] lim);
		longint l;
		l = longint'(lim);
		if (v > l)
			return l;
		if (v < -l)
			return -l;
		return v;
	endfunction

	// rate in rad/s (Q.FRAC) to a wheel command byte, truncated and saturated
	function automatic logic [SPD_W-1:0] wheel_speed(longint rate);
		longint q;
		if (rate <= 0)
			return '0;
		q = (rate * longint'(SPEED_NUM)) / (longint'(SPEED_DEN) << FRAC);
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	// one control tick: sensor byte in, wheel command out, state advanced
	function automatic wheel_cmd_t steer_step(logic [SENS_W-1:0] c);
		int         n;
		longint     mag;
		longint     err;
		longint     pid;
		longint     turn;
		wheel_cmd_t r;
		// line error, rounded half away from zero so it is symmetric
		n = 2 * int'(c) - 255;
		mag = (n < 0) ? -n : n;
		mag = ((mag << FRAC) + ERR_DIV / 2) / ERR_DIV;
		err = (n < 0) ? -mag : mag;
		err_sum = clamp_sym(err_sum + err, model_cfg.ilim);
		pid = scaled_by_gain(err, model_cfg.kp)
			+ scaled_by_gain(err_sum, model_cfg.ki)
			+ scaled_by_gain(err - prev_err, model_cfg.kd);
		turn = clamp_sym(scaled_by_gain(pid, model_cfg.kg), model_cfg.tlim);
		prev_err = err;
		r.l_speed = wheel_speed(longint'(model_cfg.base) - turn);
		r.r_speed = wheel_speed(longint'(model_cfg.base) + turn);
		r.non_neg = (err >= 0);
		return r;
	endfunction

	// register write as the block applies it: masked to width, bad index dropped
	function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] data);
		case (idx)
			REG_KP:   model_cfg.kp = data[GAIN_W-1:0];
			REG_KI:   model_cfg.ki = data[GAIN_W-1:0];
			REG_KD:   model_cfg.kd = data[GAIN_W-1:0];
			REG_KG:   model_cfg.kg = data[GAIN_W-1:0];
			REG_ILIM: model_cfg.ilim = data;
			REG_TLIM: model_cfg.tlim = data;
			REG_BASE: model_cfg.base = data;
			default: ;
		endcase
	endfunction

	// random register value: extremes now and then, mostly a usable range
	function automatic logic [LIM_W-1:0] pick_value(logic [CFG_IDX_W-1:0] idx);
		logic [LIM_W-1:0] hi;
		case (idx)
			REG_KP:   hi = 31'(60 << GAIN_FRAC);
			REG_KI:   hi = 31'(20 << GAIN_FRAC);
			REG_KD:   hi = 31'(60 << GAIN_FRAC);
			REG_KG:   hi = 31'(3 << GAIN_FRAC);
			REG_ILIM: hi = 31'(1 << 26);
			REG_TLIM: hi = 31'(1 << 28);
			default:  hi = 31'd700000000;
		endcase
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 31'($urandom);
			default: return 31'($urandom_range(0, hi));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// directed plan rows
	// ---------------------------------------------------------------

	task automatic plan_item(logic [SENS_W-1:0] c);
		plan.push_back('{ROW_ITEM, '0, 31'(c), 1'b0, '0});
	endtask

	task automatic plan_checked(logic [SENS_W-1:0] c, logic [7:0] l, logic [7:0] r, logic f);
		wheel_cmd_t w;
		w = '{l, r, f};
		plan.push_back('{ROW_ITEM, '0, 31'(c), 1'b1, w});
	endtask

	task automatic plan_write(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] data);
		plan.push_back('{ROW_WRITE, idx, data, 1'b0, '0});
	endtask

	// ---------------------------------------------------------------
	// channel drivers
	// ---------------------------------------------------------------

	// offer one sensor item and hold it until taken; valid is left high so a
	// following item can go out back to back
	task automatic send_item(logic [SENS_W-1:0] c, bit typed, wheel_cmd_t want);
		wheel_cmd_t got;
		cfg_valid <= 1'b0;
		in_valid <= 1'b1;
		sensor_byte <= c;
		do
			@(posedge clk);
		while (!in_ready);
		got = steer_step(c);
		pending_cmds.push_back(typed ? want : got);
	endtask

	// stop offering items and wait until every wheel command has come back
	task automatic finish_items();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_write(idx, data);
	endtask

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	initial begin
		int         sent;
		int         burst;
		int         style;
		int         walk_pos;
		int         held;
		logic [7:0] c;

		model_cfg = '{KP_RST, KI_RST, KD_RST, KG_RST, ILIM_RST, TLIM_RST, BASE_RST};
		err_sum = 0;
		prev_err = 0;
		walk_pos = 128;
		held = 0;

		// reset defaults: kp 30, no i or d term, so full-scale bytes give a
		// fixed turn of +/- 0.04*30 around the base rate
		plan_checked(8'd0, 8'd191, 8'd168, 1'b0);
		plan_checked(8'd255, 8'd168, 8'd191, 1'b1);
		// just either side of center, and one step in from each end
		plan_item(8'd127);
		plan_item(8'd128);
		plan_item(8'd1);
		plan_item(8'd254);
		// zero base rate: one wheel goes non-positive and stops
		plan_write(REG_BASE, '0);
		plan_item(8'd0);
		plan_item(8'd255);
		// full base rate: both wheels saturate
		plan_write(REG_BASE, '1);
		plan_checked(8'd0, 8'd255, 8'd255, 1'b0);
		plan_checked(8'd255, 8'd255, 8'd255, 1'b1);
		// huge derivative gain, upper data bits must be masked off
		plan_write(REG_BASE, BASE_RST);
		plan_write(REG_KD, 31'h7FFFFFFF);
		plan_item(8'd0);
		plan_item(8'd255);
		plan_item(8'd0);
		// integral runs into a small limit
		plan_write(REG_KD, '0);
		plan_write(REG_KI, 31'h55FFFFFF);
		plan_write(REG_ILIM, 31'd1000000);
		plan_item(8'd255);
		plan_item(8'd255);
		plan_item(8'd255);
		// limit lowered under the held integral, clamped on the next tick
		plan_write(REG_ILIM, 31'd100);
		plan_item(8'd128);
		plan_item(8'd0);
		// zero overall gain: no turn at all
		plan_write(REG_KG, '0);
		plan_checked(8'd0, 8'd179, 8'd179, 1'b0);
		plan_write(REG_KG, 31'h00FFFFFF);
		plan_item(8'd255);
		// zero turn limit: no turn either
		plan_write(REG_TLIM, '0);
		plan_checked(8'd37, 8'd179, 8'd179, 1'b0);
		// write to a missing register is dropped
		plan_write(REG_TLIM, '1);
		plan_write(REG_NONE, 31'h2AAAAAAA);
		plan_item(8'd200);
		plan_write(REG_KP, '0);
		plan_write(REG_KI, '0);
		plan_item(8'd90);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				finish_items();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_item(plan[i].data[7:0], plan[i].typed, plan[i].want);
			end
		end

		// random phases, each with its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			finish_items();
			// phase 1 all zeros, phase 2 all ones, the rest drawn at random
			for (int r = 0; r <= int'(REG_BASE); r++) begin
				if (phase == 1)
					write_reg(3'(r), '0);
				else if (phase == 2)
					write_reg(3'(r), '1);
				else
					write_reg(3'(r), pick_value(3'(r)));
			end
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_NONE, 31'($urandom));

			// long receiver hold-off while items keep coming, fills the block
			if (phase == 4 || phase == 9) begin
				cfg_valid <= 1'b0;
				hold_kick <= 1'b1;
				@(posedge clk);
				hold_kick <= 1'b0;
			end

			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				burst = $urandom_range(1, 40);
				// noise, a drifting line, a steady reading or a one-sided run
				style = $urandom_range(0, 5);
				held = $urandom_range(0, 255);
				for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
					case (style)
						0: c = 8'($urandom_range(0, 255));
						1, 2, 3: begin
							walk_pos = walk_pos + int'($urandom_range(0, 16)) - 8;
							if (walk_pos < 0)
								walk_pos = 0;
							if (walk_pos > 255)
								walk_pos = 255;
							c = 8'(walk_pos);
						end
						4: c = 8'(held);
						default: begin
							if (held[0])
								c = 8'($urandom_range(128, 255));
							else
								c = 8'($urandom_range(0, 127));
						end
					endcase
					send_item(c, 1'b0, '0);
					sent++;
				end
				// idle gap after most bursts, none after some
				if ($urandom_range(0, 3) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 25)) @(posedge clk);
				end
			end
		end

		finish_items();
		// keep running after the last result to catch stray results
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------
	// receiver: rotating stall pattern plus an occasional long hold-off
	// ---------------------------------------------------------------

	int rx_cyc = 0;
	int hold_left = 0;

	always @(posedge clk) begin
		rx_cyc++;
		if (hold_kick)
			hold_left = HOLD_CYCLES;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case ((rx_cyc / 150) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= rx_cyc[2];
			endcase
		end
	end

	// ---------------------------------------------------------------
	// result check against the oldest pending wheel command
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		wheel_cmd_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cmds.size() == 0) begin
				$error("result with none pending: left %0d right %0d flag %0d",
					left_speed, right_speed, error_non_negative);
				errors++;
			end else begin
				w = pending_cmds.pop_front();
				if (left_speed !== w.l_speed) begin
					$error("left_speed: expected %0d, got %0d", w.l_speed, left_speed);
					errors++;
				end
				if (right_speed !== w.r_speed) begin
					$error("right_speed: expected %0d, got %0d", w.r_speed, right_speed);
					errors++;
				end
				if (error_non_negative !== w.non_neg) begin
					$error("error_non_negative: expected %0d, got %0d",
						w.non_neg, error_non_negative);
					errors++;
				end
			end
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#10000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### pid_differential_drive_speed.f
rtl/pdds_pkg.sv
rtl/pdds_cfg.sv
rtl/pdds_ctrl.sv
rtl/pdds_dp.sv
rtl/pid_differential_drive_speed.sv
rtl/pdds_checker.sv
tb/sv/pid_differential_drive_speed_tb.sv
